[src/fresnel_reflectance_assert.svh]
// Assertion macros used by the checker file fr_checker.sv.
`ifndef FRESNEL_REFLECTANCE_ASSERT_SVH
`define FRESNEL_REFLECTANCE_ASSERT_SVH

// Same-cycle implication under the active-low reset.
`define FR_ASSERT_NOW(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("fresnel_reflectance: assertion failed");

// Next-cycle implication under the active-low reset.
`define FR_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("fresnel_reflectance: assertion failed");

`endif

[src/fr_pkg.sv]
`timescale 1ns / 1ps

package fr_pkg;

    // Direction component width and derived fixed-point widths
    localparam int COMPONENT_BITS = 16;
    localparam int PROD_W         = 2 * COMPONENT_BITS;
    localparam int SH             = 2 * (COMPONENT_BITS - 2) - 16;
    localparam int FP_W           = PROD_W - SH;
    localparam int SUM_W          = FP_W + 2;
    localparam int DOT_W          = 18;
    localparam int IDX_W          = 16;
    localparam int KR_W           = 16;

    localparam logic [IDX_W-1:0] IDX_OPAQUE = 16'hFFFF;
    localparam logic [IDX_W-1:0] IDX_ONE    = 16'd4096;
    localparam logic [KR_W-1:0]  KR_ONE     = 16'd32768;

    // Iteration counts of the pipelined dividers and root
    localparam int QD_STEPS = 32;
    localparam int SQ_STEPS = 17;
    localparam int RD_STEPS = 31;

    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] incident_x;
        logic signed [COMPONENT_BITS-1:0] incident_y;
        logic signed [COMPONENT_BITS-1:0] incident_z;
        logic signed [COMPONENT_BITS-1:0] normal_x;
        logic signed [COMPONENT_BITS-1:0] normal_y;
        logic signed [COMPONENT_BITS-1:0] normal_z;
        logic [IDX_W-1:0]                 refr_index;
    } t_fr_in;

    typedef struct packed {
        logic [KR_W-1:0] reflect_ratio;
        logic            total_reflect;
    } t_fr_out;

endpackage

[src/fresnel_reflectance.sv]
`timescale 1ns / 1ps
// Channel  | valid        | stall        | payload
// input    | i_in_valid   | o_in_stall   | i_in_data  (t_fr_in)
// output   | o_out_valid  | i_out_stall  | o_out_data (t_fr_out)
//
// One transaction accepted per cycle while the output is not stalled; the pipe holds the
// 32-step index divider, 17-step root and 31-step ratio dividers.
// Synchronous active-low reset clears all stage valid bits.
// A stalled result freezes the whole pipe; the input stalls only then.
module fresnel_reflectance (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  fr_pkg::t_fr_in  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output fr_pkg::t_fr_out o_out_data
);
    import fr_pkg::*;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] low;
        logic [31:0] quo;
        logic [31:0] q;
        logic [31:0] subl;
        logic [16:0] c;
        logic [15:0] n;
        logic        leave;
        logic        tr;
    } t_qd;

    typedef struct packed {
        logic [17:0] rem;
        logic [16:0] root;
        logic [33:0] val;
        logic [16:0] c;
        logic [15:0] n;
        logic        leave;
        logic        tr;
    } t_sq;

    typedef struct packed {
        logic [33:0] rem1;
        logic [30:0] low1;
        logic [30:0] quo1;
        logic [33:0] den1;
        logic        z1;
        logic [33:0] rem2;
        logic [30:0] low2;
        logic [30:0] quo2;
        logic [33:0] den2;
        logic        z2;
        logic        tr;
    } t_rd;

    logic en;
    logic r_out_valid;
    t_fr_out r_out_data;

    // Whole pipe advances unless a finished result is held
    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Stage 1: component products
    logic r1_v;
    logic signed [PROD_W-1:0] r1_px, r1_py, r1_pz;
    logic [IDX_W-1:0] r1_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in_valid;
        end
        if (en) begin
            r1_px <= i_in_data.incident_x * i_in_data.normal_x;
            r1_py <= i_in_data.incident_y * i_in_data.normal_y;
            r1_pz <= i_in_data.incident_z * i_in_data.normal_z;
            r1_n  <= i_in_data.refr_index;
        end
    end

    // Stage 2: floored sum, clamp to [-1,1], index fixup
    logic r2_v;
    logic signed [DOT_W-1:0] r2_dot;
    logic [IDX_W-1:0] r2_n;
    logic r2_opq;
    logic signed [FP_W-1:0] n_fx, n_fy, n_fz;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [DOT_W-1:0] n_dot;

    always_comb begin
        n_fx  = FP_W'(r1_px >>> SH);
        n_fy  = FP_W'(r1_py >>> SH);
        n_fz  = FP_W'(r1_pz >>> SH);
        n_sum = SUM_W'(n_fx) + SUM_W'(n_fy) + SUM_W'(n_fz);
        if (n_sum > 65536) begin
            n_dot = DOT_W'(65536);
        end else if (n_sum < -65536) begin
            n_dot = DOT_W'(-65536);
        end else begin
            n_dot = DOT_W'(n_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
        if (en) begin
            r2_dot <= n_dot;
            r2_n   <= (r1_n == '0) ? IDX_W'(1) : r1_n;
            r2_opq <= (r1_n == IDX_OPAQUE);
        end
    end

    // Stage 3: |cosi|, its square, index square
    logic r3_v;
    logic [33:0] r3_cc;
    logic [31:0] r3_q;
    logic [16:0] r3_c;
    logic [15:0] r3_n;
    logic r3_leave, r3_opq;
    logic [16:0] n_c;

    assign n_c = r2_dot[DOT_W-1] ? 17'(-r2_dot) : 17'(r2_dot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
        if (en) begin
            r3_cc    <= {17'b0, n_c} * {17'b0, n_c};
            r3_q     <= {16'b0, r2_n} * {16'b0, r2_n};
            r3_c     <= n_c;
            r3_n     <= r2_n;
            r3_leave <= (r2_dot > 0);
            r3_opq   <= r2_opq;
        end
    end

    // Stage 4: S = 1 - cosi^2 in Q.32
    logic r4_v;
    logic [32:0] r4_s;
    logic [31:0] r4_q;
    logic [16:0] r4_c;
    logic [15:0] r4_n;
    logic r4_leave, r4_opq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
        if (en) begin
            r4_s     <= 33'(34'h1_0000_0000 - r3_cc);
            r4_q     <= r3_q;
            r4_c     <= r3_c;
            r4_n     <= r3_n;
            r4_leave <= r3_leave;
            r4_opq   <= r3_opq;
        end
    end

    // Stage 5: q*S and the entering TIR compare
    logic r5_v;
    logic [63:0] r5_qs;
    logic r5_tire;
    logic [32:0] r5_s;
    logic [31:0] r5_q;
    logic [16:0] r5_c;
    logic [15:0] r5_n;
    logic r5_leave, r5_opq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= r4_v;
        end
        if (en) begin
            r5_qs    <= {32'b0, r4_q} * {31'b0, r4_s};
            r5_tire  <= ({7'b0, r4_s} >= {r4_q, 8'b0});
            r5_s     <= r4_s;
            r5_q     <= r4_q;
            r5_c     <= r4_c;
            r5_n     <= r4_n;
            r5_leave <= r4_leave;
            r5_opq   <= r4_opq;
        end
    end

    // Stage 6: TIR decision, divider setup for S*2^24/q
    logic r6_v;
    t_qd r6_qd;
    t_qd n_qd0;
    logic n_tir;

    always_comb begin
        n_tir       = r5_leave ? (r5_qs >= 64'h0100_0000_0000_0000) : r5_tire;
        n_qd0.rem   = {7'b0, r5_s[32:8]};
        n_qd0.low   = {r5_s[7:0], 24'b0};
        n_qd0.quo   = '0;
        n_qd0.q     = r5_q;
        n_qd0.subl  = r5_qs[55:24];
        n_qd0.c     = r5_c;
        n_qd0.n     = r5_n;
        n_qd0.leave = r5_leave;
        n_qd0.tr    = n_tir || r5_opq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= r5_v;
        end
        if (en) begin
            r6_qd <= n_qd0;
        end
    end

    // Restoring divider, one quotient bit per stage
    t_qd  r_qd   [QD_STEPS];
    logic r_qd_v [QD_STEPS];

    for (genvar k = 0; k < QD_STEPS; k++) begin : g_qd
        t_qd s_in, s_nx;
        logic v_in;
        logic [32:0] trial;
        if (k == 0) begin : g_first
            assign s_in = r6_qd;
            assign v_in = r6_v;
        end else begin : g_next
            assign s_in = r_qd[k-1];
            assign v_in = r_qd_v[k-1];
        end
        always_comb begin
            s_nx     = s_in;
            trial    = {s_in.rem, s_in.low[31]};
            s_nx.low = {s_in.low[30:0], 1'b0};
            if (trial >= {1'b0, s_in.q}) begin
                s_nx.rem = 32'(trial - {1'b0, s_in.q});
                s_nx.quo = {s_in.quo[30:0], 1'b1};
            end else begin
                s_nx.rem = trial[31:0];
                s_nx.quo = {s_in.quo[30:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_qd_v[k] <= 1'b0;
            end else if (en) begin
                r_qd_v[k] <= v_in;
            end
            if (en) begin
                r_qd[k] <= s_nx;
            end
        end
    end

    // Stage 7: cost^2 = 1 - sint^2, root setup
    logic r7_v;
    t_sq r7_sq;
    t_sq n_sq0;
    logic [31:0] n_sub;
    logic [32:0] n_v2;

    always_comb begin
        n_sub       = r_qd[QD_STEPS-1].leave ? r_qd[QD_STEPS-1].subl
                                             : r_qd[QD_STEPS-1].quo;
        n_v2        = 33'h1_0000_0000 - {1'b0, n_sub};
        n_sq0.rem   = '0;
        n_sq0.root  = '0;
        n_sq0.val   = {1'b0, n_v2};
        n_sq0.c     = r_qd[QD_STEPS-1].c;
        n_sq0.n     = r_qd[QD_STEPS-1].n;
        n_sq0.leave = r_qd[QD_STEPS-1].leave;
        n_sq0.tr    = r_qd[QD_STEPS-1].tr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= r_qd_v[QD_STEPS-1];
        end
        if (en) begin
            r7_sq <= n_sq0;
        end
    end

    // Digit-by-digit square root, one result bit per stage
    t_sq  r_sq   [SQ_STEPS];
    logic r_sq_v [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        t_sq s_in, s_nx;
        logic v_in;
        logic [19:0] cur, trial;
        if (k == 0) begin : g_first
            assign s_in = r7_sq;
            assign v_in = r7_v;
        end else begin : g_next
            assign s_in = r_sq[k-1];
            assign v_in = r_sq_v[k-1];
        end
        always_comb begin
            s_nx     = s_in;
            cur      = {s_in.rem, s_in.val[33:32]};
            trial    = {1'b0, s_in.root, 2'b01};
            s_nx.val = {s_in.val[31:0], 2'b00};
            if (cur >= trial) begin
                s_nx.rem  = 18'(cur - trial);
                s_nx.root = {s_in.root[15:0], 1'b1};
            end else begin
                s_nx.rem  = cur[17:0];
                s_nx.root = {s_in.root[15:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k] <= 1'b0;
            end else if (en) begin
                r_sq_v[k] <= v_in;
            end
            if (en) begin
                r_sq[k] <= s_nx;
            end
        end
    end

    // Stage 8: index-weighted cosines
    logic r8_v;
    logic [32:0] r8_a1, r8_b1, r8_a2, r8_b2;
    logic r8_tr;
    logic [15:0] n_ei, n_et;
    t_sq s_last;

    assign s_last = r_sq[SQ_STEPS-1];
    assign n_ei   = s_last.leave ? s_last.n : IDX_ONE;
    assign n_et   = s_last.leave ? IDX_ONE : s_last.n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (en) begin
            r8_v <= r_sq_v[SQ_STEPS-1];
        end
        if (en) begin
            r8_a1 <= {17'b0, n_ei} * {16'b0, s_last.c};
            r8_b1 <= {17'b0, n_et} * {16'b0, s_last.root};
            r8_a2 <= {17'b0, n_et} * {16'b0, s_last.c};
            r8_b2 <= {17'b0, n_ei} * {16'b0, s_last.root};
            r8_tr <= s_last.tr;
        end
    end

    // Stage 9: ratio numerators and denominators, divider setup
    logic r9_v;
    t_rd r9_rd;
    t_rd n_rd0;
    logic [32:0] n_num1, n_num2;

    always_comb begin
        n_num1     = (r8_a1 > r8_b1) ? (r8_a1 - r8_b1) : (r8_b1 - r8_a1);
        n_num2     = (r8_a2 > r8_b2) ? (r8_a2 - r8_b2) : (r8_b2 - r8_a2);
        n_rd0.den1 = {1'b0, r8_a1} + {1'b0, r8_b1};
        n_rd0.den2 = {1'b0, r8_a2} + {1'b0, r8_b2};
        n_rd0.z1   = (n_rd0.den1 == '0);
        n_rd0.z2   = (n_rd0.den2 == '0);
        n_rd0.rem1 = {2'b0, n_num1[32:1]};
        n_rd0.rem2 = {2'b0, n_num2[32:1]};
        n_rd0.low1 = {n_num1[0], 30'b0};
        n_rd0.low2 = {n_num2[0], 30'b0};
        n_rd0.quo1 = '0;
        n_rd0.quo2 = '0;
        n_rd0.tr   = r8_tr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else if (en) begin
            r9_v <= r8_v;
        end
        if (en) begin
            r9_rd <= n_rd0;
        end
    end

    // Two-lane restoring divider for the s and p ratios
    t_rd  r_rd   [RD_STEPS];
    logic r_rd_v [RD_STEPS];

    for (genvar k = 0; k < RD_STEPS; k++) begin : g_rd
        t_rd s_in, s_nx;
        logic v_in;
        logic [34:0] trial1, trial2;
        if (k == 0) begin : g_first
            assign s_in = r9_rd;
            assign v_in = r9_v;
        end else begin : g_next
            assign s_in = r_rd[k-1];
            assign v_in = r_rd_v[k-1];
        end
        always_comb begin
            s_nx      = s_in;
            trial1    = {s_in.rem1, s_in.low1[30]};
            trial2    = {s_in.rem2, s_in.low2[30]};
            s_nx.low1 = {s_in.low1[29:0], 1'b0};
            s_nx.low2 = {s_in.low2[29:0], 1'b0};
            if (trial1 >= {1'b0, s_in.den1}) begin
                s_nx.rem1 = 34'(trial1 - {1'b0, s_in.den1});
                s_nx.quo1 = {s_in.quo1[29:0], 1'b1};
            end else begin
                s_nx.rem1 = trial1[33:0];
                s_nx.quo1 = {s_in.quo1[29:0], 1'b0};
            end
            if (trial2 >= {1'b0, s_in.den2}) begin
                s_nx.rem2 = 34'(trial2 - {1'b0, s_in.den2});
                s_nx.quo2 = {s_in.quo2[29:0], 1'b1};
            end else begin
                s_nx.rem2 = trial2[33:0];
                s_nx.quo2 = {s_in.quo2[29:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rd_v[k] <= 1'b0;
            end else if (en) begin
                r_rd_v[k] <= v_in;
            end
            if (en) begin
                r_rd[k] <= s_nx;
            end
        end
    end

    // Stage 10: squared ratios (zero denominator reads as one)
    logic r10_v;
    logic [61:0] r10_s1, r10_s2;
    logic r10_tr;
    logic [30:0] n_r1, n_r2;

    assign n_r1 = r_rd[RD_STEPS-1].z1 ? 31'h4000_0000 : r_rd[RD_STEPS-1].quo1;
    assign n_r2 = r_rd[RD_STEPS-1].z2 ? 31'h4000_0000 : r_rd[RD_STEPS-1].quo2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
        end else if (en) begin
            r10_v <= r_rd_v[RD_STEPS-1];
        end
        if (en) begin
            r10_s1 <= {31'b0, n_r1} * {31'b0, n_r1};
            r10_s2 <= {31'b0, n_r2} * {31'b0, n_r2};
            r10_tr <= r_rd[RD_STEPS-1].tr;
        end
    end

    // Output: average, round half up to Q1.15, force one on TIR/opaque
    logic [62:0] n_ksum;
    t_fr_out n_out;

    always_comb begin
        n_ksum = {1'b0, r10_s1} + {1'b0, r10_s2} + 63'h2000_0000_0000;
        n_out.total_reflect = r10_tr;
        n_out.reflect_ratio = r10_tr ? KR_ONE : n_ksum[61:46];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r10_v;
        end
        if (en) begin
            r_out_data <= n_out;
        end
    end

endmodule

[src/fr_checker.sv]
`timescale 1ns / 1ps
`include "fresnel_reflectance_assert.svh"

module fr_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input fr_pkg::t_fr_in  i_in_data,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input fr_pkg::t_fr_out o_out_data
);
    import fr_pkg::*;

    // Held result stays put
    `FR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // Stalled input transaction stays put
    `FR_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall, i_in_valid && $stable(i_in_data))

    // Input is back-pressured only by a held result
    `FR_ASSERT_NOW(a_in_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

    // Forced reflection always reads as exactly one
    `FR_ASSERT_NOW(a_tir_one, i_clk, i_rst_n, o_out_valid && o_out_data.total_reflect, o_out_data.reflect_ratio == KR_ONE)

    // Reflectance never exceeds one
    `FR_ASSERT_NOW(a_kr_range, i_clk, i_rst_n, o_out_valid, o_out_data.reflect_ratio <= KR_ONE)

endmodule

bind fresnel_reflectance fr_checker u_fr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

[tb/sv/fresnel_checker.sv]
`timescale 1ns / 1ps

module fresnel_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_stall,
    input  fr_pkg::t_fr_in  i_in_data,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  fr_pkg::t_fr_out i_out_data,
    output int              o_fail_count,
    output int              o_pending
);
    import fr_pkg::*;

    t_fr_out kr_queue[$];

    // Integer square root, floor
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        longint unsigned rem;
        res = 0;
        rem = v;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // |a-b|/(a+b) in Q.30; zero denominator gives 1.0
    function automatic longint unsigned fresnel_ratio(input longint unsigned a,
                                                      input longint unsigned b);
        longint unsigned den;
        longint unsigned num;
        den = a + b;
        num = (a > b) ? a - b : b - a;
        if (den == 0) return 64'd1 << 30;
        return (num << 30) / den;
    endfunction

    function automatic t_fr_out predict_kr(input t_fr_in d);
        longint signed dot;
        longint signed prod;
        longint unsigned n, c, s_val, q, sub, t, ei, et, rs, rp, sum;
        logic leaving, tir;
        t_fr_out r;
        // floored products, summed, clamped
        prod = longint'(d.incident_x) * longint'(d.normal_x);
        dot = prod >>> SH;
        prod = longint'(d.incident_y) * longint'(d.normal_y);
        dot = dot + (prod >>> SH);
        prod = longint'(d.incident_z) * longint'(d.normal_z);
        dot = dot + (prod >>> SH);
        if (dot > 65536) dot = 65536;
        if (dot < -65536) dot = -65536;
        n = d.refr_index;
        if (n == 0) n = 1;
        r.reflect_ratio = KR_ONE;
        r.total_reflect = 1'b1;
        if (n == 64'(IDX_OPAQUE)) return r;
        leaving = dot > 0;
        c = (dot < 0) ? -dot : dot;
        s_val = (64'd1 << 32) - c * c;
        q = n * n;
        tir = leaving ? (q * s_val >= (64'd1 << 56)) : (s_val >= (q << 8));
        if (tir) return r;
        sub = leaving ? ((q * s_val) >> 24) : ((s_val << 24) / q);
        t = floor_root((64'd1 << 32) - sub);
        ei = leaving ? n : 64'(IDX_ONE);
        et = leaving ? 64'(IDX_ONE) : n;
        rs = fresnel_ratio(ei * c, et * t);
        rp = fresnel_ratio(et * c, ei * t);
        sum = rs * rs + rp * rp;
        r.reflect_ratio = 16'((sum + (64'd1 << 45)) >> 46);
        r.total_reflect = 1'b0;
        return r;
    endfunction

    assign o_pending = kr_queue.size();

    // Predict on input transaction, compare on output transaction
    always @(posedge i_clk) begin
        t_fr_out want;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) kr_queue = {kr_queue, predict_kr(i_in_data)};
            if (i_out_valid && !i_out_stall) begin
                if (kr_queue.size() == 0) begin
                    $error("unexpected result %h", i_out_data);
                    errs++;
                end else begin
                    want = kr_queue.pop_front();
                    if (want.reflect_ratio !== i_out_data.reflect_ratio) begin
                        $error("reflect_ratio expected %0d actual %0d",
                               want.reflect_ratio, i_out_data.reflect_ratio);
                        errs++;
                    end
                    if (want.total_reflect !== i_out_data.total_reflect) begin
                        $error("total_reflect expected %0d actual %0d",
                               want.total_reflect, i_out_data.total_reflect);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end
endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import fr_pkg::*;

    localparam int LATENCY = 91;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 1900;

    logic    i_clk;
    logic    i_rst_n;
    logic    in_valid;
    logic    in_stall;
    t_fr_in  in_data;
    logic    out_valid;
    logic    out_stall;
    t_fr_out out_data;
    int      fail_count;
    int      pending;
    int      idle_cycles;
    logic    hold_off;
    logic    sending_done;

    t_fr_in  query_list[$];

    fresnel_reflectance DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    fresnel_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_fr_in make_query(input int a, b, c, d, e, f, input int idx);
        t_fr_in q;
        q.incident_x = a[15:0];
        q.incident_y = b[15:0];
        q.incident_z = c[15:0];
        q.normal_x = d[15:0];
        q.normal_y = e[15:0];
        q.normal_z = f[15:0];
        q.refr_index = idx[15:0];
        return q;
    endfunction

    // Append one query to the stimulus list
    function automatic void queue_query(input t_fr_in q);
        query_list = {query_list, q};
    endfunction

    // Random component: mostly unit-range, sometimes full range
    function automatic int rand_comp();
        if ($urandom_range(0, 4) == 0) return int'($urandom_range(0, 65535)) - 32768;
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    function automatic int rand_index();
        case ($urandom_range(0, 9))
            0: return 65535;
            1: return 0;
            2: return $urandom_range(0, 65535);
            default: return $urandom_range(4096, 12288);
        endcase
    endfunction

    // Build the query list: directed cases first
    initial begin
        int k;
        queue_query(make_query(0, 0, -16384, 0, 0, 16384, 6144));
        queue_query(make_query(0, 0, 16384, 0, 0, 16384, 6144));
        queue_query(make_query(16384, 0, 0, 0, 0, 16384, 6144));
        queue_query(make_query(11585, 0, 11585, 0, 0, 16384, 6144));
        queue_query(make_query(11585, 0, -11585, 0, 0, 16384, 6144));
        queue_query(make_query(0, 0, -16384, 0, 0, 16384, 65535));
        queue_query(make_query(0, 0, 16384, 0, 0, 16384, 65535));
        queue_query(make_query(0, 0, -16384, 0, 0, 16384, 0));
        queue_query(make_query(0, 0, 16384, 0, 0, 16384, 0));
        queue_query(make_query(0, 0, 0, 0, 0, 0, 4096));
        queue_query(make_query(0, 0, -16384, 0, 0, 16384, 4096));
        queue_query(make_query(-32768, -32768, -32768, -32768, -32768, -32768, 1));
        queue_query(make_query(-32768, -32768, -32768, 32767, 32767, 32767, 65534));
        queue_query(make_query(32767, 32767, 32767, 32767, 32767, 32767, 65535));
        queue_query(make_query(32767, -32768, 32767, -32768, 32767, -32768, 1));
        queue_query(make_query(16000, 0, 3000, 0, 0, 16384, 8192));
        queue_query(make_query(0, 0, -16384, 0, 0, 16384, 65534));
        queue_query(make_query(0, 0, -16384, 0, 0, 16384, 1));
        queue_query(make_query(0, 16384, -1, 0, 0, 16384, 6144));
        for (k = 0; k < RANDOM_ITEMS; k++)
            queue_query(make_query(rand_comp(), rand_comp(), rand_comp(),
                                   rand_comp(), rand_comp(), rand_comp(),
                                   rand_index()));
    end

    // Sender: bursts with random gaps
    initial begin
        int burst;
        int gap;
        in_valid = 1'b0;
        in_data = '0;
        sending_done = 1'b0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        #1;
        while (query_list.size() > 0) begin
            burst = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            while (burst > 0 && query_list.size() > 0) begin
                @(posedge i_clk);
                if (!in_valid || !in_stall) begin
                    if (in_valid) burst--;
                    if (burst > 0) begin
                        in_valid <= 1'b1;
                        in_data <= query_list.pop_front();
                    end else begin
                        in_valid <= 1'b0;
                    end
                end
            end
            // drain the last offered transaction
            while (in_valid) begin
                @(posedge i_clk);
                if (!in_stall) in_valid <= 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        sending_done <= 1'b1;
    end

    // Receiver: random stall pattern plus one long hold-off
    initial begin
        int hold_count;
        hold_off = 1'b0;
        @(posedge i_rst_n);
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b1;
        for (hold_count = 0; hold_count < 300; hold_count++) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        int phase;
        phase = ($time / 20) % 1000;
        if (!i_rst_n) out_stall <= 1'b0;
        else if (hold_off) out_stall <= 1'b1;
        else if (phase < 200) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(0, 3) == 0);
    end

    // Watchdog and end of run
    initial begin
        idle_cycles = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("fresnel_reflectance: mismatch");
                $finish;
            end
            if (sending_done && pending == 0) begin
                repeat (LATENCY + 20) @(posedge i_clk);
                if (fail_count == 0 && pending == 0) begin
                    $display("fresnel_reflectance: match");
                end else begin
                    $display("fresnel_reflectance: mismatch");
                end
                $finish;
            end
        end
    end
endmodule

[fresnel_reflectance.f]
+incdir+src
src/fr_pkg.sv
src/fresnel_reflectance.sv
src/fr_checker.sv
tb/sv/fresnel_checker.sv
tb/sv/testbench.sv
